### src/wcc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wcc_pkg
// shared constants and the saturating coordinate difference for the wall crossing clamp pipeline
// ----------------------------------------------------------------------------
package wcc_pkg;
  localparam int COORD_W = 32;
  localparam int DIFF_W  = 32;
  localparam int PROD_W  = 64;
  localparam int CROSS_W = 65;
  localparam logic PLANE_XZ = 1'b0;
  localparam logic PLANE_XY = 1'b1;

  // difference of two coordinates clamped to +-(2^31-1)
  function automatic logic signed [DIFF_W-1:0] sat_diff(
    input logic signed [COORD_W-1:0] a,
    input logic signed [COORD_W-1:0] b
  );
    logic signed [COORD_W:0] d;
    begin
      d = {a[COORD_W-1], a} - {b[COORD_W-1], b};
      if (d > 33'sd2147483647) sat_diff = 32'sh7fffffff;
      else if (d < -33'sd2147483647) sat_diff = -32'sh7fffffff;
      else sat_diff = d[DIFF_W-1:0];
    end
  endfunction
endpackage
`default_nettype wire

### src/wcc_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wcc_div
// pipelined restoring divider, one quotient bit per stage
// ----------------------------------------------------------------------------
module wcc_div #(
  parameter int QBITS = 16,
  parameter int DW    = 64,
  parameter int TW    = 64
) (
  input  wire logic          clk,
  input  wire logic          adv,
  input  wire logic [DW-1:0] num,
  input  wire logic [DW-1:0] den,
  input  wire logic [TW-1:0] tag_in,
  output logic [QBITS-1:0]   quo,
  output logic [TW-1:0]      tag_out
);
  logic [DW:0]      rem [QBITS+1];
  logic [DW-1:0]    dv  [QBITS+1];
  logic [QBITS-1:0] q   [QBITS+1];
  logic [TW-1:0]    tg  [QBITS+1];

  assign rem[0] = {1'b0, num};
  assign dv[0]  = den;
  assign q[0]   = '0;
  assign tg[0]  = tag_in;

  // one quotient bit per register stage
  for (genvar k = 0; k < QBITS; k++) begin : g_stage
    logic [DW+1:0] sh;
    logic [DW+1:0] df;
    assign sh = {rem[k], 1'b0};
    assign df = sh - {2'b00, dv[k]};
    always_ff @(posedge clk) begin
      if (adv) begin
        rem[k+1] <= df[DW+1] ? sh[DW:0] : df[DW:0];
        q[k+1]   <= {q[k][QBITS-2:0], ~df[DW+1]};
        dv[k+1]  <= dv[k];
        tg[k+1]  <= tg[k];
      end
    end
  end

  assign quo     = q[QBITS];
  assign tag_out = tg[QBITS];
endmodule
`default_nettype wire

### src/wall_crossing_clamp_top.sv
`timescale 1ns / 1ps
`default_nettype none
// path: stages 1 to 4, the divider, stages 5 and 6, from input request to result request
// throughput: one request per cycle while the output is not stalled; the divider has one stage per rate bit
// a stall at the output freezes the whole pipeline, nothing is lost
// reset clears the stage valid bits and plane_select to the xz plane
// ----------------------------------------------------------------------------
// wall_crossing_clamp_top
// snaps a moving point onto a crossed wall segment, fully pipelined
// ----------------------------------------------------------------------------
module wall_crossing_clamp_top
  import wcc_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic cfg_we,
  input  wire logic cfg_wdata,
  input  wire logic in_valid,
  output logic      in_stall,
  input  wire logic signed [31:0] target_x,
  input  wire logic signed [31:0] target_y,
  input  wire logic signed [31:0] target_z,
  input  wire logic signed [31:0] prev_x,
  input  wire logic signed [31:0] prev_y,
  input  wire logic signed [31:0] prev_z,
  input  wire logic signed [31:0] right_x,
  input  wire logic signed [31:0] right_y,
  input  wire logic signed [31:0] right_z,
  input  wire logic signed [31:0] left_x,
  input  wire logic signed [31:0] left_y,
  input  wire logic signed [31:0] left_z,
  output logic      out_valid,
  input  wire logic out_stall,
  output logic      hit,
  output logic      parallel,
  output logic signed [31:0] out_x,
  output logic signed [31:0] out_y,
  output logic signed [31:0] out_z
);
  localparam int TB = FRAC_BITS + 1;
  localparam int DL = FRAC_BITS + 6;

  logic plane_select;
  logic adv;
  logic [DL-1:0] vld;

  // whole pipeline moves unless a held result is stalled
  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;
  assign out_valid = vld[DL-1];

  always_ff @(posedge clk) begin
    if (rst) plane_select <= PLANE_XZ;
    else if (cfg_we) plane_select <= cfg_wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else if (adv) vld <= {vld[DL-2:0], in_valid};
  end

  // stage 1: saturated differences, plane pick
  logic signed [31:0] s1_tgt [3], s1_lft [3], s1_wl [3];
  logic signed [31:0] s1_ma, s1_mb, s1_ta, s1_tb, s1_wa, s1_wb;
  logic signed [31:0] mv [3], wl [3], tp [3];
  always_comb begin
    mv[0] = sat_diff(target_x, prev_x);
    mv[1] = sat_diff(target_y, prev_y);
    mv[2] = sat_diff(target_z, prev_z);
    wl[0] = sat_diff(right_x, left_x);
    wl[1] = sat_diff(right_y, left_y);
    wl[2] = sat_diff(right_z, left_z);
    tp[0] = sat_diff(target_x, left_x);
    tp[1] = sat_diff(target_y, left_y);
    tp[2] = sat_diff(target_z, left_z);
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_tgt <= '{target_x, target_y, target_z};
      s1_lft <= '{left_x, left_y, left_z};
      s1_wl  <= wl;
      if (plane_select == PLANE_XY) begin
        s1_ma <= mv[0]; s1_mb <= mv[1];
        s1_ta <= tp[0]; s1_tb <= tp[1];
        s1_wa <= wl[0]; s1_wb <= wl[1];
      end else begin
        s1_ma <= mv[2]; s1_mb <= mv[0];
        s1_ta <= tp[2]; s1_tb <= tp[0];
        s1_wa <= wl[2]; s1_wb <= wl[0];
      end
    end
  end

  // stage 2: six products
  logic signed [63:0] p_s1, p_s2, p_n1, p_n2, p_d1, p_d2;
  logic signed [31:0] s2_tgt [3], s2_lft [3], s2_wl [3];
  always_ff @(posedge clk) begin
    if (adv) begin
      p_s1 <= s1_wa * s1_tb; p_s2 <= s1_wb * s1_ta;
      p_n1 <= s1_ta * s1_mb; p_n2 <= s1_tb * s1_ma;
      p_d1 <= s1_wa * s1_mb; p_d2 <= s1_wb * s1_ma;
      s2_tgt <= s1_tgt; s2_lft <= s1_lft; s2_wl <= s1_wl;
    end
  end

  // stage 3: cross products, decision, magnitudes
  logic signed [CROSS_W-1:0] side, num, den;
  logic [CROSS_W-1:0] un, ud;
  assign side = CROSS_W'(p_s1) - CROSS_W'(p_s2);
  assign num  = CROSS_W'(p_n1) - CROSS_W'(p_n2);
  assign den  = CROSS_W'(p_d1) - CROSS_W'(p_d2);
  assign un = num[CROSS_W-1] ? CROSS_W'(-num) : num;
  assign ud = den[CROSS_W-1] ? CROSS_W'(-den) : den;

  logic s3_par, s3_cand;
  logic [63:0] s3_un, s3_ud;
  logic signed [31:0] s3_tgt [3], s3_lft [3], s3_wl [3];
  always_ff @(posedge clk) begin
    if (adv) begin
      s3_par  <= (den == '0);
      s3_cand <= (den != '0) && side[CROSS_W-1] &&
                 ((num == '0) || (num[CROSS_W-1] == den[CROSS_W-1]));
      s3_un <= un[63:0]; s3_ud <= ud[63:0];
      s3_tgt <= s2_tgt; s3_lft <= s2_lft; s3_wl <= s2_wl;
    end
  end

  // stage 4: range check, divider feed
  logic s4_par, s4_hit, s4_full;
  logic [63:0] s4_un, s4_ud;
  logic signed [31:0] s4_tgt [3], s4_lft [3], s4_wl [3];
  always_ff @(posedge clk) begin
    if (adv) begin
      s4_par  <= s3_par;
      s4_hit  <= s3_cand && (s3_un <= s3_ud);
      s4_full <= (s3_un >= s3_ud);
      s4_un <= s3_un; s4_ud <= s3_ud;
      s4_tgt <= s3_tgt; s4_lft <= s3_lft; s4_wl <= s3_wl;
    end
  end

  // fractional rate through the divider, side data as tag
  localparam int TAGW = 3 + 9 * 32;
  logic [TAGW-1:0] tag_in, tag_out;
  logic [FRAC_BITS-1:0] quo;
  assign tag_in = {s4_par, s4_hit, s4_full,
                   s4_tgt[0], s4_tgt[1], s4_tgt[2],
                   s4_lft[0], s4_lft[1], s4_lft[2],
                   s4_wl[0], s4_wl[1], s4_wl[2]};
  wcc_div #(.QBITS(FRAC_BITS), .DW(64), .TW(TAGW)) u_div (
    .clk(clk), .adv(adv),
    .num(s4_un), .den(s4_ud), .tag_in(tag_in),
    .quo(quo), .tag_out(tag_out)
  );

  logic d_par, d_hit, d_full;
  logic signed [31:0] d_tgt [3], d_lft [3], d_wl [3];
  assign {d_par, d_hit, d_full, d_tgt[0], d_tgt[1], d_tgt[2],
          d_lft[0], d_lft[1], d_lft[2], d_wl[0], d_wl[1], d_wl[2]} = tag_out;
  logic signed [TB:0] rate;
  assign rate = d_full ? (TB+1)'(1) <<< FRAC_BITS : {2'b00, quo};

  // stage 5: scale wall by rate
  logic s5_par, s5_hit;
  logic signed [32+TB:0] s5_p [3];
  logic signed [31:0] s5_tgt [3], s5_lft [3];
  always_ff @(posedge clk) begin
    if (adv) begin
      s5_par <= d_par; s5_hit <= d_hit;
      for (int k = 0; k < 3; k++) begin
        s5_p[k] <= (33+TB)'(d_wl[k]) * (33+TB)'(rate);
      end
      s5_tgt <= d_tgt; s5_lft <= d_lft;
    end
  end

  // stage 6: truncate toward zero, add left, saturate
  logic signed [32+TB:0] mg [3], sc [3];
  logic signed [33+TB:0] sm [3];
  logic signed [31:0] res [3];
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      mg[k] = s5_p[k][32+TB] ? -s5_p[k] : s5_p[k];
      mg[k] = mg[k] >>> FRAC_BITS;
      sc[k] = s5_p[k][32+TB] ? -mg[k] : mg[k];
      sm[k] = (34+TB)'(s5_lft[k]) + (34+TB)'(sc[k]);
      if (sm[k] > (34+TB)'(64'sd2147483647)) res[k] = 32'sh7fffffff;
      else if (sm[k] < -(34+TB)'(64'sd2147483648)) res[k] = 32'sh80000000;
      else res[k] = sm[k][31:0];
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      hit      <= s5_hit;
      parallel <= s5_par;
      out_x <= s5_hit ? res[0] : s5_tgt[0];
      out_y <= s5_hit ? res[1] : s5_tgt[1];
      out_z <= s5_hit ? res[2] : s5_tgt[2];
    end
  end

  // a hit and parallel movement exclude each other
  a_hit_par: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(hit && parallel)) else $error("hit with parallel");
  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_x) && $stable(hit))
    else $error("result changed under stall");
  // input stall only while a result is stalled
  a_stall: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall) else $error("spurious input stall");
endmodule
`default_nettype wire

### dv/wall_crossing_clamp_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wall_crossing_clamp_top_tb
// drives point / wall requests into the clamp pipeline and checks every
// result against a bit-true predictor or a hand-written expected result, under random idling on both sides
// ----------------------------------------------------------------------------
module wall_crossing_clamp_top_tb
  import wcc_pkg::*;
;

  localparam int FRAC_BITS  = 16;
  localparam int LATENCY    = FRAC_BITS + 6;
  localparam int CYCLE_MAX  = 400000;
  localparam int HOLD_LEN   = 300;
  localparam int RAND_ITEMS = 200;
  localparam logic [31:0] ONE = 32'h0001_0000;

  // request: target, prev, right, left, each x/y/z
  typedef logic [11:0][31:0] query_t;
  typedef struct packed {
    logic        hit;
    logic        par;
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
  } clamp_res_t;
  typedef struct {
    bit         typed;
    clamp_res_t res;
  } pend_t;
  typedef struct {
    logic       plane;
    bit         typed;
    query_t     q;
    clamp_res_t res;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic cfg_wdata = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  query_t req_q = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic hit, parallel;
  logic signed [31:0] out_x, out_y, out_z;

  logic plane_reg = PLANE_XZ;
  clamp_res_t snap_q[$];
  pend_t      typed_q[$];
  row_t       rows[$];
  int err_cnt = 0;
  int cycles = 0;
  int snd_pct = 0;
  int rcv_pct = 0;
  bit hold_go = 1'b0;
  int hold_cnt = 0;

  wall_crossing_clamp_top #(.FRAC_BITS(FRAC_BITS)) dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall),
    .target_x(req_q[0]), .target_y(req_q[1]), .target_z(req_q[2]),
    .prev_x(req_q[3]), .prev_y(req_q[4]), .prev_z(req_q[5]),
    .right_x(req_q[6]), .right_y(req_q[7]), .right_z(req_q[8]),
    .left_x(req_q[9]), .left_y(req_q[10]), .left_z(req_q[11]),
    .out_valid(out_valid), .out_stall(out_stall),
    .hit(hit), .parallel(parallel), .out_x(out_x), .out_y(out_y), .out_z(out_z)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_MAX) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // coordinate difference clamped to +-(2^31-1)
  function automatic longint clip_diff(longint p, longint m);
    longint d;
    d = p - m;
    if (d > 64'sd2147483647) d = 64'sd2147483647;
    if (d < -64'sd2147483647) d = -64'sd2147483647;
    return d;
  endfunction

  function automatic longint cross_ab(longint ua, longint ub, longint va, longint vb);
    return ua * vb - ub * va;
  endfunction

  // expected result of one request in the selected plane
  function automatic clamp_res_t clamp_predict(query_t q, logic plane);
    longint tg[3], lf[3], mv[3], wl[3], tp[3], rs[3];
    longint side, num, den, rate, p, s;
    longint unsigned un, ud, rem;
    int a, b;
    clamp_res_t r;
    for (int k = 0; k < 3; k++) begin
      tg[k] = longint'($signed(q[k]));
      lf[k] = longint'($signed(q[9+k]));
      mv[k] = clip_diff(tg[k], longint'($signed(q[3+k])));
      wl[k] = clip_diff(longint'($signed(q[6+k])), lf[k]);
      tp[k] = clip_diff(tg[k], lf[k]);
      rs[k] = tg[k];
    end
    if (plane == PLANE_XY) begin
      a = 0; b = 1;
    end else begin
      a = 2; b = 0;
    end
    side = cross_ab(wl[a], wl[b], tp[a], tp[b]);
    num  = cross_ab(tp[a], tp[b], mv[a], mv[b]);
    den  = cross_ab(wl[a], wl[b], mv[a], mv[b]);
    r.hit = 1'b0;
    r.par = (den == 0);
    un = (num < 0) ? -num : num;
    ud = (den < 0) ? -den : den;
    if (!r.par && side < 0 && (num == 0 || ((num < 0) == (den < 0))) && un <= ud) begin
      // long division for the rate, FRAC_BITS quotient bits
      if (un >= ud) rate = longint'(1) << FRAC_BITS;
      else begin
        rem = un;
        rate = 0;
        for (int k = 0; k < FRAC_BITS; k++) begin
          rem = rem << 1;
          rate = rate << 1;
          if (rem >= ud) begin
            rem = rem - ud;
            rate = rate | 1;
          end
        end
      end
      for (int k = 0; k < 3; k++) begin
        p = wl[k] * rate;
        p = (p >= 0) ? (p >>> FRAC_BITS) : -((-p) >>> FRAC_BITS);
        s = lf[k] + p;
        if (s > 64'sd2147483647) s = 64'sd2147483647;
        if (s < -64'sd2147483648) s = -64'sd2147483648;
        rs[k] = s;
      end
      r.hit = 1'b1;
    end
    r.x = rs[0][31:0];
    r.y = rs[1][31:0];
    r.z = rs[2][31:0];
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h expected %h at cycle %0d", what, got, want, cycles);
    err_cnt++;
  endtask

  // request acceptance and result checking
  always @(posedge clk) begin
    pend_t pe;
    clamp_res_t e;
    if (!rst && in_valid && !in_stall) begin
      pe = typed_q.pop_front();
      snap_q.push_back(pe.typed ? pe.res : clamp_predict(req_q, plane_reg));
    end
    if (!rst && out_valid && !out_stall) begin
      if (snap_q.size() == 0) report_mismatch("result with none pending", out_x, 32'd0);
      else begin
        e = snap_q.pop_front();
        if (hit !== e.hit) report_mismatch("hit", 32'(hit), 32'(e.hit));
        if (parallel !== e.par) report_mismatch("parallel", 32'(parallel), 32'(e.par));
        if (out_x !== e.x) report_mismatch("out_x", out_x, e.x);
        if (out_y !== e.y) report_mismatch("out_y", out_y, e.y);
        if (out_z !== e.z) report_mismatch("out_z", out_z, e.z);
      end
    end
  end

  // result side stall, with an occasional long hold-off
  always @(posedge clk) begin
    if (hold_go) begin
      hold_go = 1'b0;
      hold_cnt = HOLD_LEN;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < rcv_pct);
    end
  end

  function automatic query_t mkq(logic [31:0] tx, ty, tz, px, py, pz,
                                 rx, ry, rz, lx, ly, lz);
    return {lz, ly, lx, rz, ry, rx, pz, py, px, tz, ty, tx};
  endfunction

  function automatic clamp_res_t mkr(logic h, logic p, logic [31:0] x, y, z);
    clamp_res_t r;
    r.hit = h; r.par = p; r.x = x; r.y = y; r.z = z;
    return r;
  endfunction

  function automatic void add_row(logic plane, bit typed, query_t q, clamp_res_t r);
    row_t w;
    w.plane = plane; w.typed = typed; w.q = q; w.res = r;
    rows.push_back(w);
  endfunction

  function automatic logic [31:0] near_coord();
    return $urandom_range(32'h0010_0000) - 32'h0008_0000;
  endfunction

  function automatic logic [31:0] odd_coord();
    case ($urandom_range(5))
      0: return 32'h0000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'h8000_0000;
      3: return 32'hffff_ffff;
      4: return 32'h0000_0001;
      default: return $urandom;
    endcase
  endfunction

  // mostly real crossings of a random wall, some loose points, some noise
  function automatic query_t rand_query();
    query_t q;
    int kind;
    logic signed [31:0] c, d;
    kind = $urandom_range(99);
    for (int k = 0; k < 12; k++) q[k] = near_coord();
    if (kind < 55) begin
      for (int k = 0; k < 3; k++) begin
        c = $signed(q[9+k]) +
            (($signed(q[6+k]) - $signed(q[9+k])) * $signed($urandom_range(256))) / 256;
        d = $signed(near_coord()) / 4;
        q[3+k] = c + d;
        q[k] = c - d;
      end
    end else if (kind < 80) begin
      for (int k = 0; k < 12; k++) q[k] = $urandom;
    end else if (kind < 90) begin
      for (int k = 0; k < 12; k++) q[k] = odd_coord();
    end
    return q;
  endfunction

  // one edge first so the last accepted request is already pending
  task automatic wait_drained();
    @(posedge clk);
    while (snap_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_plane(logic p);
    wait_drained();
    repeat (LATENCY + 4) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= p;
    @(posedge clk);
    cfg_we <= 1'b0;
    plane_reg = p;
  endtask

  // offer one request and hold it until accepted
  task automatic send_query(query_t q, bit typed, clamp_res_t r);
    pend_t pe;
    while ($urandom_range(99) < snd_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    pe.typed = typed;
    pe.res = r;
    typed_q.push_back(pe);
    in_valid <= 1'b1;
    req_q <= q;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic random_phase(logic plane, int sp, int rp, bit pressure);
    write_plane(plane);
    snd_pct = sp;
    rcv_pct = rp;
    for (int i = 0; i < RAND_ITEMS; i++) begin
      if (pressure && i == 40) hold_go = 1'b1;
      if (pressure && i == 120) begin
        in_valid <= 1'b0;
        @(posedge clk);
        wait_drained();
      end
      send_query(rand_query(), 1'b0, '0);
    end
    in_valid <= 1'b0;
  endtask

  initial begin
    // directed rows, geometry in units of 1.0
    add_row(PLANE_XZ, 1, '0, mkr(0, 1, 0, 0, 0));
    add_row(PLANE_XZ, 1, mkq(ONE, 0, ONE, ONE, 0, -ONE, 2*ONE, 0, 0, 0, 0, 0),
            mkr(1, 0, ONE, 0, 0));
    add_row(PLANE_XZ, 1, mkq(ONE, 0, -ONE, ONE, 0, ONE, 2*ONE, 0, 0, 0, 0, 0),
            mkr(0, 0, ONE, 0, -ONE));
    add_row(PLANE_XZ, 1, mkq(3*ONE, 4*ONE, 5*ONE, 3*ONE, 4*ONE, 5*ONE, 1, 2, 3, 4, 5, 6),
            mkr(0, 1, 3*ONE, 4*ONE, 5*ONE));
    add_row(PLANE_XZ, 0, mkq(0, 7*ONE, ONE, 0, -ONE, -ONE, 2*ONE, ONE, 0, 0, 0, 0), '0);
    add_row(PLANE_XZ, 0, mkq(2*ONE, 0, ONE, 2*ONE, 0, -ONE, 2*ONE, 0, 0, 0, 0, 0), '0);
    add_row(PLANE_XZ, 0, mkq(5*ONE, 0, ONE, 5*ONE, 0, -ONE, 2*ONE, 0, 0, 0, 0, 0), '0);
    add_row(PLANE_XZ, 0, mkq('1, '1, '1, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
            32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 0, 0, 0), '0);
    add_row(PLANE_XZ, 0, mkq(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
            32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff,
            32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff), '0);
    add_row(PLANE_XZ, 0, mkq(32'h7fff_0000, 0, 32'h0001_0000, 32'h7fff_0000, 0,
            32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 0,
            32'h7fff_0000, 32'h7fff_0000, 0), '0);
    add_row(PLANE_XY, 1, mkq(ONE, -ONE, 0, ONE, ONE, 0, 2*ONE, 0, 0, 0, 0, 0),
            mkr(1, 0, ONE, 0, 0));
    add_row(PLANE_XY, 1, mkq(ONE, 0, ONE, ONE, 0, -ONE, 2*ONE, 0, 0, 0, 0, 0),
            mkr(0, 1, ONE, 0, ONE));
    add_row(PLANE_XY, 0, mkq(ONE, -ONE, 9*ONE, ONE, ONE, -9*ONE,
            2*ONE, 0, 4*ONE, 0, 0, -4*ONE), '0);
    add_row(PLANE_XY, 0, mkq(0, -ONE, 0, 0, ONE, 0, 2*ONE, 0, 0, 0, 0, 0), '0);
    add_row(PLANE_XY, 0, mkq(32'h8000_0000, 32'h8000_0000, 0, 32'h7fff_ffff,
            32'h7fff_ffff, 0, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
            32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff), '0);
    add_row(PLANE_XY, 0, mkq(32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555,
            32'haaaa_aaaa, 32'h5555_5555, 32'haaaa_aaaa, 32'h1234_5678, 32'h8765_4321,
            32'hdead_beef, 32'h0f0f_0f0f, 32'hf0f0_f0f0, 32'h3c3c_3c3c), '0);

    // reset
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table, plane switched only when idle
    foreach (rows[i]) begin
      if (rows[i].plane != plane_reg) begin
        in_valid <= 1'b0;
        write_plane(rows[i].plane);
      end
      send_query(rows[i].q, rows[i].typed, rows[i].res);
    end
    in_valid <= 1'b0;

    // random phases with the idling mix changing
    random_phase(PLANE_XZ, 34, 55, 1'b1);
    random_phase(PLANE_XY, 55, 34, 1'b0);
    random_phase(PLANE_XZ, 0, 0, 1'b0);

    // drain and settle
    wait_drained();
    repeat (LATENCY + 10) @(posedge clk);
    if (err_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule

### files.f
src/wcc_pkg.sv
src/wcc_div.sv
src/wall_crossing_clamp_top.sv
dv/wall_crossing_clamp_top_tb.sv
